// File: design/mmde_pkg.sv
// ----------------------------------------------------------------------------
// mmde_pkg
// Shared types and constants of the matrix multiply dot engine.
// ----------------------------------------------------------------------------
package mmde_pkg;

	// Largest matrix edge; stores hold MAX_SIZE x MAX_SIZE elements
	localparam int MAX_SIZE = 16;
	localparam int IDX_W    = $clog2(MAX_SIZE);
	localparam int DEPTH    = MAX_SIZE * MAX_SIZE;
	localparam int ADDR_W   = 2 * IDX_W;

	// Element, product and accumulator widths
	localparam int ELEM_W = 16;
	localparam int PROD_W = 2 * ELEM_W;
	localparam int ACC_W  = 36;

	// Configuration register
	localparam int SIZE_W      = 5;
	localparam int APB_ADDR_W  = 3;
	localparam int APB_DATA_W  = 32;
	localparam logic [0:0] REG_MATRIX_SIZE = 1'b0;
	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);
	localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_SIZE);

	// Input actions
	localparam int ACT_W = 2;
	localparam logic [ACT_W-1:0] ACT_WRITE_A = 2'd0;
	localparam logic [ACT_W-1:0] ACT_WRITE_B = 2'd1;
	localparam logic [ACT_W-1:0] ACT_REQUEST = 2'd2;

	// Control from the sequencer to the multiply-accumulate unit
	typedef struct packed {
		logic clear;  // zero the accumulator
		logic valid;  // read data from both stores is present this cycle
		logic last;   // this is the final term of the sum
	} mmde_mac_ctrl_t;

endpackage

// File: design/matrix_multiply_dot_engine.sv
// ----------------------------------------------------------------------------
// matrix_multiply_dot_engine
// Element-wise loaded square matrix multiply returning one C element per request.
// ----------------------------------------------------------------------------
// Load A and B one element per transaction (action write A / write B, row, col,
// value), then request any element of C with action request; the engine answers
// with the exact sum over k < size of A[row][k] * B[k][col] in 36-bit two's
// complement. Writes complete in the cycle they are accepted. A request in
// range goes through the store reads, the product register and the
// accumulator to the output register: one multiply-accumulate per cycle,
// fed by one read of each element store per cycle, and that single read
// port of each store sets the rate. A request with row or col at or beyond
// the size answers with a zero sum and range_error set. One transaction is
// worked on at a time; the next one is taken as soon as the previous result has
// been moved into the output register, even while that result waits on
// out_ready. The size register sits at byte address 0 of the APB port, resets
// to 16, and a value above 16 is used as 16; a size of zero flags every
// request. Requests must only read elements that were written before.
// ----------------------------------------------------------------------------
module matrix_multiply_dot_engine import mmde_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// APB configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	// input channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [ACT_W-1:0]      action,
	input  logic [IDX_W-1:0]      row,
	input  logic [IDX_W-1:0]      col,
	input  logic [ELEM_W-1:0]     value,
	// output channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [ACC_W-1:0]      product_sum,
	output logic [IDX_W-1:0]      out_row,
	output logic [IDX_W-1:0]      out_col,
	output logic                  range_error
);

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;  // take a transaction
	localparam logic [1:0] ST_RUN  = 2'd1;  // issue one read pair per cycle
	localparam logic [1:0] ST_WAIT = 2'd2;  // let the accumulator drain
	localparam logic [1:0] ST_OUT  = 2'd3;  // move the result into the output register

	logic [1:0]        state_q;
	logic [SIZE_W-1:0] size_q;
	logic [SIZE_W-1:0] n_use;
	logic [SIZE_W-1:0] n_last;
	logic              in_range;
	logic              in_fire;
	logic              cfg_write;

	logic [IDX_W-1:0]  row_q;
	logic [IDX_W-1:0]  col_q;
	logic [IDX_W-1:0]  k_q;
	logic              err_q;
	logic              k_last;
	logic              issue_s1;
	logic              last_s1;
	logic              start;

	logic              we_a;
	logic              we_b;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] a_raddr;
	logic [ADDR_W-1:0] b_raddr;
	logic [ELEM_W-1:0] a_rdata;
	logic [ELEM_W-1:0] b_rdata;

	mmde_mac_ctrl_t    mac_ctrl;
	logic [ACC_W-1:0]  mac_acc;
	logic              mac_done;

	logic              out_valid_q;
	logic [ACC_W-1:0]  sum_q;
	logic [IDX_W-1:0]  out_row_q;
	logic [IDX_W-1:0]  out_col_q;
	logic              out_err_q;
	logic              out_free;

	// ---------------- configuration ----------------
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_MATRIX_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
		end else if (cfg_write) begin
			size_q <= pwdata[SIZE_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_MATRIX_SIZE) ?
		{{(APB_DATA_W-SIZE_W){1'b0}}, size_q} : '0;

	// clamp the size to the store edge; n_last is only used when n_use is nonzero
	assign n_use    = (size_q > SIZE_MAX) ? SIZE_MAX : size_q;
	assign n_last   = n_use - SIZE_W'(1);
	assign in_range = (SIZE_W'(row) < n_use) && (SIZE_W'(col) < n_use);

	// ---------------- input side ----------------
	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign start    = in_fire && (action == ACT_REQUEST);

	// writes land in the store at the accepting edge; out-of-range writes drop
	assign we_a  = in_fire && (action == ACT_WRITE_A) && in_range;
	assign we_b  = in_fire && (action == ACT_WRITE_B) && in_range;
	assign waddr = {row, col};

	// A is walked along the row, B down the column
	assign a_raddr = {row_q, k_q};
	assign b_raddr = {k_q, col_q};
	assign k_last  = (k_q == n_last[IDX_W-1:0]);

	mmde_ram #(
		.WIDTH (ELEM_W),
		.DEPTH (DEPTH)
	) u_a_store (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr),
		.wdata (value),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	mmde_ram #(
		.WIDTH (ELEM_W),
		.DEPTH (DEPTH)
	) u_b_store (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr),
		.wdata (value),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	// ---------------- sequencer ----------------
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			issue_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			// read data returns in the cycle after the address; tag it here
			issue_s1 <= (state_q == ST_RUN);
			last_s1  <= (state_q == ST_RUN) && k_last;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= in_range ? ST_RUN : ST_OUT;
					end
				end
				ST_RUN: begin
					if (k_last) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (mac_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request payload and term counter
	always_ff @(posedge clk) begin
		if (start) begin
			row_q <= row;
			col_q <= col;
			err_q <= !in_range;
			k_q   <= '0;
		end else if (state_q == ST_RUN) begin
			k_q <= k_q + IDX_W'(1);
		end
	end

	// ---------------- multiply-accumulate ----------------
	assign mac_ctrl.clear = start;
	assign mac_ctrl.valid = issue_s1;
	assign mac_ctrl.last  = last_s1;

	mmde_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.a_data (a_rdata),
		.b_data (b_rdata),
		.acc    (mac_acc),
		.done   (mac_done)
	);

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_OUT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && out_free) begin
			sum_q     <= err_q ? '0 : mac_acc;
			out_row_q <= row_q;
			out_col_q <= col_q;
			out_err_q <= err_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign product_sum = sum_q;
	assign out_row     = out_row_q;
	assign out_col     = out_col_q;
	assign range_error = out_err_q;

endmodule

// File: design/mmde_ram.sv
// ----------------------------------------------------------------------------
// mmde_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mmde_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: design/mmde_mac.sv
// ----------------------------------------------------------------------------
// mmde_mac
// Multiply-accumulate unit: registered 16x16 product, then 36-bit accumulate.
// ----------------------------------------------------------------------------
module mmde_mac import mmde_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  mmde_mac_ctrl_t    ctrl,
	input  logic [ELEM_W-1:0] a_data,
	input  logic [ELEM_W-1:0] b_data,
	output logic [ACC_W-1:0]  acc,
	output logic              done
);

	logic              valid_s2;
	logic              last_s2;
	logic [PROD_W-1:0] prod_s2;
	logic [ACC_W-1:0]  acc_q;
	logic              done_q;
	logic [ACC_W-1:0]  prod_ext;

	// product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			last_s2  <= 1'b0;
		end else begin
			valid_s2 <= ctrl.valid;
			last_s2  <= ctrl.valid & ctrl.last;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= PROD_W'($signed(a_data) * $signed(b_data));
	end

	assign prod_ext = {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};

	// accumulate stage; the sum wraps at the accumulator width
	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= acc_q + prod_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s2 & last_s2;
		end
	end

	assign acc  = acc_q;
	assign done = done_q;

endmodule
